### rtl/btpl_pkg.sv
package btpl_pkg;

    localparam int NODE_COUNT_DEF = 4096;
    localparam int PORT_BITS_DEF  = 16;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 6;
    localparam int IN_PORT_W  = 16;
    localparam int OUT_PORT_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [OUT_PORT_W-1:0] match_port;
        logic                  hit;
        logic                  table_full;
    } result_t;

endpackage

### rtl/btpl_ram.sv
module btpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/btpl_walker.sv
module btpl_walker #(
    parameter int NODE_COUNT = btpl_pkg::NODE_COUNT_DEF,
    parameter int PORT_BITS  = btpl_pkg::PORT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [btpl_pkg::OP_W-1:0]          op,
    input  logic [btpl_pkg::ADDR_W-1:0]        address,
    input  logic [btpl_pkg::LEN_W-1:0]         prefix_length,
    input  logic [btpl_pkg::IN_PORT_W-1:0]     port,
    output logic                               res_valid,
    output btpl_pkg::result_t                  res,
    input  logic                               res_take
);

    localparam int NW      = $clog2(NODE_COUNT);
    localparam int ENTRY_W = 2 * NW + 1 + PORT_BITS;

    typedef struct packed {
        logic [NW-1:0]        zero_child;
        logic [NW-1:0]        one_child;
        logic                 flag;
        logic [PORT_BITS-1:0] node_port;
    } node_t;

    btpl_pkg::state_t             state_reg, state_next;
    btpl_pkg::op_t                op_reg, op_next;
    logic [btpl_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [btpl_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [PORT_BITS-1:0]         port_reg, port_next;
    logic [btpl_pkg::LEN_W-1:0]   level_reg, level_next;
    logic [NW-1:0]                cur_reg, cur_next;
    node_t                        cur_node_reg, cur_node_next;
    logic                         from_ram_reg, from_ram_next;
    logic [NW:0]                  next_free_reg, next_free_next;
    node_t                        root_reg, root_next;
    logic                         found_reg, found_next;
    logic [PORT_BITS-1:0]         best_reg, best_next;
    btpl_pkg::result_t            res_reg, res_next;

    logic                ram_we;
    logic [NW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [NW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    node_t                entry;
    node_t                wr_node;
    logic                 wr_en;
    logic                 addr_bit;
    logic [NW-1:0]        child;
    logic                 walk_flag;
    logic [PORT_BITS-1:0] walk_best;

    btpl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign entry     = from_ram_reg ? node_t'(ram_rdata) : cur_node_reg;
    assign addr_bit  = addr_reg[~level_reg[4:0]];
    assign child     = addr_bit ? entry.one_child : entry.zero_child;
    assign walk_flag = found_reg | entry.flag;
    assign walk_best = entry.flag ? entry.node_port : best_reg;

    assign ram_raddr = child;
    assign ram_waddr = cur_reg;
    assign ram_wdata = ENTRY_W'(wr_node);
    assign ram_we    = wr_en && (cur_reg != '0);

    assign in_stall  = (state_reg != btpl_pkg::S_IDLE);
    assign res_valid = (state_reg == btpl_pkg::S_RESP);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= btpl_pkg::S_IDLE;
            next_free_reg <= (NW+1)'(1);
            root_reg      <= '0;
            from_ram_reg  <= 1'b0;
            level_reg     <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            root_reg      <= root_next;
            from_ram_reg  <= from_ram_next;
            level_reg     <= level_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        port_reg     <= port_next;
        cur_reg      <= cur_next;
        cur_node_reg <= cur_node_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        port_next      = port_reg;
        level_next     = level_reg;
        cur_next       = cur_reg;
        cur_node_next  = cur_node_reg;
        from_ram_next  = from_ram_reg;
        next_free_next = next_free_reg;
        root_next      = root_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_node        = entry;

        unique case (state_reg)
            btpl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = btpl_pkg::op_t'(op);
                    addr_next     = address;
                    len_next      = prefix_length;
                    port_next     = PORT_BITS'(port);
                    level_next    = '0;
                    cur_next      = '0;
                    cur_node_next = root_reg;
                    from_ram_next = 1'b0;
                    found_next    = 1'b0;
                    best_next     = '0;
                    res_next      = '0;
                    unique case (op)
                        btpl_pkg::OP_LOOKUP:
                        begin
                            state_next = btpl_pkg::S_WALK;
                        end
                        btpl_pkg::OP_INSERT:
                        begin
                            if (prefix_length > btpl_pkg::LEN_W'(btpl_pkg::ADDR_W))
                            begin
                                state_next = btpl_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = btpl_pkg::S_WALK;
                            end
                        end
                        btpl_pkg::OP_CLEAR:
                        begin
                            root_next      = '0;
                            next_free_next = (NW+1)'(1);
                            state_next     = btpl_pkg::S_RESP;
                        end
                        default:
                        begin
                            state_next = btpl_pkg::S_RESP;
                        end
                    endcase
                end
            end

            btpl_pkg::S_WALK:
            begin
                if (op_reg == btpl_pkg::OP_LOOKUP)
                begin
                    found_next = walk_flag;
                    best_next  = walk_best;
                    if ((level_reg == btpl_pkg::LEN_W'(btpl_pkg::ADDR_W)) || (child == '0))
                    begin
                        res_next.match_port = btpl_pkg::OUT_PORT_W'(walk_best);
                        res_next.hit        = walk_flag;
                        res_next.table_full = 1'b0;
                        state_next          = btpl_pkg::S_RESP;
                    end
                    else
                    begin
                        cur_next      = child;
                        from_ram_next = 1'b1;
                        level_next    = level_reg + 1'b1;
                    end
                end
                else
                begin
                    priority if (level_reg == len_reg)
                    begin
                        wr_node.flag      = 1'b1;
                        wr_node.node_port = port_reg;
                        wr_en             = 1'b1;
                        state_next        = btpl_pkg::S_RESP;
                    end
                    else if (child != '0)
                    begin
                        cur_next      = child;
                        from_ram_next = 1'b1;
                        level_next    = level_reg + 1'b1;
                    end
                    else if (next_free_reg >= (NW+1)'(NODE_COUNT))
                    begin
                        wr_en               = 1'b1;
                        res_next.table_full = 1'b1;
                        state_next          = btpl_pkg::S_RESP;
                    end
                    else
                    begin
                        if (addr_bit)
                        begin
                            wr_node.one_child = next_free_reg[NW-1:0];
                        end
                        else
                        begin
                            wr_node.zero_child = next_free_reg[NW-1:0];
                        end
                        wr_en          = 1'b1;
                        cur_next       = next_free_reg[NW-1:0];
                        cur_node_next  = '0;
                        from_ram_next  = 1'b0;
                        next_free_next = next_free_reg + 1'b1;
                        level_next     = level_reg + 1'b1;
                    end
                    if (wr_en && (cur_reg == '0))
                    begin
                        root_next = wr_node;
                    end
                end
            end

            btpl_pkg::S_RESP:
            begin
                if (res_take)
                begin
                    state_next = btpl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = btpl_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != '0) && (next_free_reg <= (NW+1)'(NODE_COUNT)))
        else $error("free node counter out of range");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= btpl_pkg::LEN_W'(btpl_pkg::ADDR_W))
        else $error("walk level beyond address width");

    a_write_in_insert: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == btpl_pkg::S_WALK) && (op_reg == btpl_pkg::OP_INSERT))
        else $error("node memory written outside an insert walk");

    a_hit_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.hit) |-> (op_reg == btpl_pkg::OP_LOOKUP))
        else $error("hit reported for an operation other than lookup");

    a_full_from_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.table_full) |->
            ((op_reg == btpl_pkg::OP_INSERT) && (next_free_reg == (NW+1)'(NODE_COUNT))))
        else $error("table full reported while free nodes remain");
`endif

endmodule

### rtl/binary_trie_prefix_lookup.sv
// IPv4 longest-prefix-match engine on a binary trie, one address bit per level.
// Input channel: in_valid/in_stall carry op, address, prefix_length and port.
// A beat is taken when in_valid is high and in_stall is low; op selects a
// lookup, an insert of a prefix or a clear of the whole table.
// Output channel: out_valid/out_stall carry match_port, hit and table_full,
// exactly one result beat for every input beat, in order.
// The engine works on one beat at a time. The walk visits one trie level per
// clock, limited by the single read port of the node memory, whose read data
// is registered. A clear or an ignored beat is answered without a walk.
// The next beat is taken at the edge after the hand-over.
// While the receiver stalls, the result beat is held in the output register;
// a following beat may still be processed and then waits until it drains.
// Reset leaves an empty trie with the output register empty; no clearing pass
// runs over the node memory, since nodes are written in full as they are
// handed out.
module binary_trie_prefix_lookup #(
    parameter int NODE_COUNT = btpl_pkg::NODE_COUNT_DEF,
    parameter int PORT_BITS  = btpl_pkg::PORT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [btpl_pkg::OP_W-1:0]          op,
    input  logic [btpl_pkg::ADDR_W-1:0]        address,
    input  logic [btpl_pkg::LEN_W-1:0]         prefix_length,
    input  logic [btpl_pkg::IN_PORT_W-1:0]     port,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [btpl_pkg::OUT_PORT_W-1:0]    match_port,
    output logic                               hit,
    output logic                               table_full
);

    logic              res_valid;
    logic              res_take;
    btpl_pkg::result_t res;

    logic              out_valid_reg, out_valid_next;
    btpl_pkg::result_t out_reg, out_next;

    btpl_walker #(
        .NODE_COUNT (NODE_COUNT),
        .PORT_BITS  (PORT_BITS)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .address       (address),
        .prefix_length (prefix_length),
        .port          (port),
        .res_valid     (res_valid),
        .res           (res),
        .res_take      (res_take)
    );

    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign match_port = out_reg.match_port;
    assign hit        = out_reg.hit;
    assign table_full = out_reg.table_full;

endmodule

### tb/binary_trie_prefix_lookup_tb.sv
module binary_trie_prefix_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = btpl_pkg::NODE_COUNT_DEF;
    localparam logic [btpl_pkg::OUT_PORT_W-1:0] PORT_MASK =
        btpl_pkg::OUT_PORT_W'((1 << btpl_pkg::PORT_BITS_DEF) - 1);
    localparam logic [btpl_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
    localparam btpl_pkg::result_t NO_RES = '0;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int TAIL_CYCLES = 40;
    localparam int PRINT_LIMIT = 40;
    localparam int DIR_ROWS = 25;

    typedef struct packed {
        logic [btpl_pkg::OP_W-1:0]      code;
        logic [btpl_pkg::ADDR_W-1:0]    addr;
        logic [btpl_pkg::LEN_W-1:0]     len;
        logic [btpl_pkg::IN_PORT_W-1:0] fwd;
        logic                           has_want;
        btpl_pkg::result_t              want;
    } stim_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [btpl_pkg::OP_W-1:0]         op = btpl_pkg::OP_LOOKUP;
    logic [btpl_pkg::ADDR_W-1:0]       address = '0;
    logic [btpl_pkg::LEN_W-1:0]        prefix_length = '0;
    logic [btpl_pkg::IN_PORT_W-1:0]    port = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [btpl_pkg::OUT_PORT_W-1:0]   match_port;
    logic                              hit;
    logic                              table_full;

    logic                              tag_fixed = 1'b0;
    btpl_pkg::result_t                 tag_want = '0;
    logic                              long_hold = 1'b0;
    event                              hold_start;

    int                                send_idle_pct = 0;
    int                                stall_pct = 0;
    int                                beats_sent = 0;
    int                                results_seen = 0;
    int                                mismatch_count = 0;
    int                                hit_count = 0;
    int                                full_count = 0;
    int                                quiet_cycles = 0;

    int unsigned                       zero_link [NODES];
    int unsigned                       one_link [NODES];
    bit                                route_end [NODES];
    logic [btpl_pkg::OUT_PORT_W-1:0]   route_port [NODES];
    int unsigned                       alloc_ptr;

    btpl_pkg::result_t                 due_results [$];
    logic [btpl_pkg::ADDR_W-1:0]       seen_addrs [$];
    stim_row_t                         dir_rows [DIR_ROWS];

    binary_trie_prefix_lookup u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .address       (address),
        .prefix_length (prefix_length),
        .port          (port),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .match_port    (match_port),
        .hit           (hit),
        .table_full    (table_full)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic btpl_pkg::result_t route_beat(
        logic [btpl_pkg::OP_W-1:0] code, logic [btpl_pkg::ADDR_W-1:0] a,
        logic [btpl_pkg::LEN_W-1:0] len, logic [btpl_pkg::IN_PORT_W-1:0] p);
        btpl_pkg::result_t r;
        int unsigned       cur;
        int unsigned       nxt;
        int                i;
        bit                done;
        r = '0;
        cur = 0;
        done = 1'b0;
        if (code == btpl_pkg::OP_LOOKUP)
        begin
            if (route_end[0])
            begin
                r.hit = 1'b1;
                r.match_port = route_port[0];
            end
            for (i = 0; i < 32 && !done; i++)
            begin
                nxt = a[31-i] ? one_link[cur] : zero_link[cur];
                if (nxt == 0)
                    done = 1'b1;
                else
                begin
                    cur = nxt;
                    if (route_end[cur])
                    begin
                        r.hit = 1'b1;
                        r.match_port = route_port[cur];
                    end
                end
            end
        end
        else if (code == btpl_pkg::OP_INSERT && len <= 32)
        begin
            for (i = 0; i < len && !done; i++)
            begin
                nxt = a[31-i] ? one_link[cur] : zero_link[cur];
                if (nxt == 0)
                begin
                    if (alloc_ptr >= NODES)
                    begin
                        r.table_full = 1'b1;
                        done = 1'b1;
                    end
                    else
                    begin
                        nxt = alloc_ptr;
                        alloc_ptr++;
                        zero_link[nxt] = 0;
                        one_link[nxt] = 0;
                        route_end[nxt] = 1'b0;
                        route_port[nxt] = '0;
                        if (a[31-i])
                            one_link[cur] = nxt;
                        else
                            zero_link[cur] = nxt;
                    end
                end
                if (!done)
                    cur = nxt;
            end
            if (!r.table_full)
            begin
                route_end[cur] = 1'b1;
                route_port[cur] = p & PORT_MASK;
            end
        end
        else if (code == btpl_pkg::OP_CLEAR)
        begin
            zero_link[0] = 0;
            one_link[0] = 0;
            route_end[0] = 1'b0;
            alloc_ptr = 1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: mismatch on result beat %0d, %s: got 0x%0h, expected 0x%0h",
                     $realtime, results_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result();
        btpl_pkg::result_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch("result beat with nothing outstanding", 64'(match_port), 64'(0));
            return;
        end
        want = due_results.pop_front();
        if (match_port !== want.match_port)
            report_mismatch("match_port", 64'(match_port), 64'(want.match_port));
        if (hit !== want.hit)
            report_mismatch("hit", 64'(hit), 64'(want.hit));
        if (table_full !== want.table_full)
            report_mismatch("table_full", 64'(table_full), 64'(want.table_full));
    endtask

    always @(posedge clk)
    begin : scoreboard
        btpl_pkg::result_t predicted;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
                results_seen++;
                if (hit === 1'b1)
                    hit_count++;
                if (table_full === 1'b1)
                    full_count++;
            end
            if (in_valid && !in_stall)
            begin
                predicted = route_beat(op, address, prefix_length, port);
                due_results.push_back(tag_fixed ? tag_want : predicted);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_CYCLES);
            $display("** binary_trie_prefix_lookup: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= long_hold || ($urandom_range(0, 99) < stall_pct);

    initial
    begin
        forever
        begin
            @(hold_start);
            long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            long_hold <= 1'b0;
        end
    end

    task automatic offer_beat(logic [btpl_pkg::OP_W-1:0] code,
                              logic [btpl_pkg::ADDR_W-1:0] a,
                              logic [btpl_pkg::LEN_W-1:0] len,
                              logic [btpl_pkg::IN_PORT_W-1:0] p,
                              logic has_want, btpl_pkg::result_t want);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        op            <= code;
        address       <= a;
        prefix_length <= len;
        port          <= p;
        tag_fixed     <= has_want;
        tag_want      <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic wait_drained();
        while (results_seen < beats_sent)
            @(posedge clk);
    endtask

    function automatic logic [btpl_pkg::ADDR_W-1:0] near_known();
        logic [btpl_pkg::ADDR_W-1:0] base;
        if (seen_addrs.size() == 0 || $urandom_range(0, 3) == 0)
            return $urandom;
        base = seen_addrs[$urandom_range(0, seen_addrs.size() - 1)];
        return base ^ ($urandom >> $urandom_range(0, 32));
    endfunction

    task automatic remember(logic [btpl_pkg::ADDR_W-1:0] a);
        seen_addrs.push_back(a);
        if (seen_addrs.size() > 256)
            void'(seen_addrs.pop_front());
    endtask

    task automatic offer_random();
        int                             pick;
        int                             lpick;
        logic [btpl_pkg::ADDR_W-1:0]    a;
        logic [btpl_pkg::LEN_W-1:0]     len;
        logic [btpl_pkg::IN_PORT_W-1:0] p;
        pick = $urandom_range(0, 99);
        lpick = $urandom_range(0, 99);
        a = $urandom;
        p = btpl_pkg::IN_PORT_W'($urandom);
        if (lpick < 4)
            len = btpl_pkg::LEN_W'($urandom_range(33, 63));
        else if (lpick < 70)
            len = btpl_pkg::LEN_W'($urandom_range(0, 16));
        else
            len = btpl_pkg::LEN_W'($urandom_range(17, 32));
        if (pick < 3)
            offer_beat(btpl_pkg::OP_CLEAR, a, len, p, 1'b0, NO_RES);
        else if (pick < 5)
            offer_beat(OP_RESERVED, a, len, p, 1'b0, NO_RES);
        else if (pick < 45)
        begin
            remember(a);
            offer_beat(btpl_pkg::OP_INSERT, a, len, p, 1'b0, NO_RES);
        end
        else
            offer_beat(btpl_pkg::OP_LOOKUP, near_known(), len, p, 1'b0, NO_RES);
    endtask

    task automatic offer_filling();
        int                             pick;
        logic [btpl_pkg::ADDR_W-1:0]    a;
        logic [btpl_pkg::IN_PORT_W-1:0] p;
        pick = $urandom_range(0, 99);
        a = $urandom;
        p = btpl_pkg::IN_PORT_W'($urandom);
        if (pick < 65)
        begin
            remember(a);
            offer_beat(btpl_pkg::OP_INSERT, a, 6'd32, p, 1'b0, NO_RES);
        end
        else if (pick < 72)
            offer_beat(btpl_pkg::OP_INSERT, a, btpl_pkg::LEN_W'($urandom_range(8, 31)), p,
                       1'b0, NO_RES);
        else if (pick < 80 && seen_addrs.size() != 0)
            offer_beat(btpl_pkg::OP_INSERT,
                       seen_addrs[$urandom_range(0, seen_addrs.size() - 1)],
                       6'd32, p, 1'b0, NO_RES);
        else
            offer_beat(btpl_pkg::OP_LOOKUP, near_known(), btpl_pkg::LEN_W'($urandom), p,
                       1'b0, NO_RES);
    endtask

    task automatic run_phase(int idle_pct, int stall_in, int count, bit filling);
        int n;
        send_idle_pct = idle_pct;
        stall_pct = stall_in;
        for (n = 0; n < count; n++)
        begin
            if (filling)
                offer_filling();
            else
                offer_random();
        end
    endtask

    initial
    begin
        int i;
        dir_rows = '{
            '{btpl_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000, 1'b1, NO_RES},
            '{btpl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  16'h0000, 1'b1, NO_RES},
            '{btpl_pkg::OP_INSERT, 32'h0000_0000, 6'd0,  16'hABCD, 1'b1, NO_RES},
            '{btpl_pkg::OP_LOOKUP, 32'h1234_5678, 6'd0,  16'h0000, 1'b1,
              '{16'hABCD, 1'b1, 1'b0}},
            '{btpl_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF, 1'b1, NO_RES},
            '{btpl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  16'h0000, 1'b1,
              '{16'hFFFF, 1'b1, 1'b0}},
            '{btpl_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 6'd0,  16'h0000, 1'b0, NO_RES},
            '{btpl_pkg::OP_INSERT, 32'h0000_0000, 6'd32, 16'h0000, 1'b1, NO_RES},
            '{btpl_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000, 1'b0, NO_RES},
            '{btpl_pkg::OP_INSERT, 32'h0A00_0000, 6'd8,  16'h0010, 1'b0, NO_RES},
            '{btpl_pkg::OP_INSERT, 32'h0A01_0000, 6'd16, 16'h0020, 1'b0, NO_RES},
            '{btpl_pkg::OP_LOOKUP, 32'h0A01_0203, 6'd0,  16'h0000, 1'b0, NO_RES},
            '{btpl_pkg::OP_LOOKUP, 32'h0A02_0304, 6'd0,  16'h0000, 1'b0, NO_RES},
            '{btpl_pkg::OP_INSERT, 32'h0A00_0000, 6'd8,  16'h5555, 1'b0, NO_RES},
            '{btpl_pkg::OP_LOOKUP, 32'h0A02_0304, 6'd0,  16'h0000, 1'b0, NO_RES},
            '{btpl_pkg::OP_INSERT, 32'h0B00_0000, 6'd33, 16'h1234, 1'b1, NO_RES},
            '{btpl_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1'b1, NO_RES},
            '{OP_RESERVED,         32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1'b1, NO_RES},
            '{btpl_pkg::OP_INSERT, 32'h8000_0000, 6'd1,  16'h0001, 1'b0, NO_RES},
            '{btpl_pkg::OP_LOOKUP, 32'h8000_0001, 6'd0,  16'h0000, 1'b0, NO_RES},
            '{btpl_pkg::OP_CLEAR,  32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1'b1, NO_RES},
            '{btpl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  16'h0000, 1'b1, NO_RES},
            '{btpl_pkg::OP_LOOKUP, 32'h0A01_0203, 6'd0,  16'h0000, 1'b1, NO_RES},
            '{btpl_pkg::OP_INSERT, 32'hC0A8_0000, 6'd24, 16'h0300, 1'b0, NO_RES},
            '{btpl_pkg::OP_LOOKUP, 32'hC0A8_00FF, 6'd0,  16'h0000, 1'b0, NO_RES}
        };
        for (i = 0; i < NODES; i++)
        begin
            zero_link[i] = 0;
            one_link[i] = 0;
            route_end[i] = 1'b0;
            route_port[i] = '0;
        end
        alloc_ptr = 1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
            offer_beat(dir_rows[i].code, dir_rows[i].addr, dir_rows[i].len, dir_rows[i].fwd,
                       dir_rows[i].has_want, dir_rows[i].want);

        run_phase(0, 0, 100, 1'b0);
        run_phase(48, 0, 110, 1'b0);
        run_phase(0, 48, 110, 1'b0);
        run_phase(13, 13, 110, 1'b0);

        // Start from an empty trie and keep adding host routes until the node memory runs out.
        offer_beat(btpl_pkg::OP_CLEAR, $urandom, btpl_pkg::LEN_W'($urandom),
                   btpl_pkg::IN_PORT_W'($urandom), 1'b1, NO_RES);
        run_phase(13, 13, 260, 1'b1);

        // The receiver holds off for a long stretch while beats keep coming, then the sender
        // waits for every outstanding result before the last few beats.
        send_idle_pct = 0;
        stall_pct = 0;
        -> hold_start;
        run_phase(0, 0, 12, 1'b0);
        in_valid <= 1'b0;
        wait_drained();
        run_phase(0, 48, 8, 1'b0);
        in_valid <= 1'b0;
        stall_pct = 0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
            report_mismatch("results never returned", 64'(due_results.size()), 64'(0));

        $display("Run covered %0d beats: lookups, inserts, clears and unused opcodes.",
                 beats_sent);
        $display("It saw %0d lookup hits and %0d inserts refused for want of free nodes.",
                 hit_count, full_count);
        if (mismatch_count == 0)
            $display("** binary_trie_prefix_lookup: PASSED **");
        else
            $display("** binary_trie_prefix_lookup: FAILED **");
        $finish;
    end

endmodule
